// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/uri_pkg.sv =====
// Shared types, constants and helper functions of the URI percent encoder.
package uri_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0] CHAR_PCT = 7'h25;

    typedef enum logic [1:0] {
        CMD_PASS,
        CMD_ERROR,
        CMD_UTF8
    } cmd_kind_t;

    typedef enum logic [1:0] {
        DIG_PCT,
        DIG_HI,
        DIG_LO
    } digit_t;

    // One queued job: a pass-through char, an error, or 1..4 UTF-8 bytes.
    typedef struct packed {
        cmd_kind_t   kind;
        logic        run_last;   // m_tlast of an error job
        logic [6:0]  ch;
        logic [1:0]  nbytes_m1;
        logic [31:0] bytes;      // first byte in bits 7:0
    } cmd_t;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] c;
        if (nib < 4'd10) begin
            c = 7'h30 + {3'd0, nib};
        end else begin
            c = 7'h37 + {3'd0, nib};
        end
        return c;
    endfunction

    function automatic logic unit_passes(input logic [15:0] u, input logic keep);
        logic ok;
        ok = 1'b0;
        if ((u >= 16'h0061 && u <= 16'h007A) || (u >= 16'h0041 && u <= 16'h005A) ||
            (u >= 16'h0030 && u <= 16'h0039)) begin
            ok = 1'b1;
        end
        case (u)
            16'h002D, 16'h005F, 16'h002E, 16'h0021, 16'h007E,
            16'h002A, 16'h0027, 16'h0028, 16'h0029: begin
                ok = 1'b1;
            end
            16'h003B, 16'h002F, 16'h003F, 16'h003A, 16'h0040, 16'h0026,
            16'h003D, 16'h002B, 16'h0024, 16'h002C, 16'h0023: begin
                if (keep) begin
                    ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return ok;
    endfunction

endpackage

// ===== rtl/uri_queue.sv =====
// Short job queue between the classifier and the character generator.
module uri_queue
    import uri_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/uri_front.sv =====
// Input side: surrogate pairing, character classification and UTF-8 byte build.
module uri_front
    import uri_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tlast,
    input  logic        queue_full,
    output logic        push,
    output cmd_t        push_cmd
);

    logic       keep_reg, keep_next;
    logic       pending_reg, pending_next;
    logic [9:0] payload_reg, payload_next;
    logic       latched_reg, latched_next;

    logic        accept;
    logic        is_low, is_high;
    logic [20:0] pair_cp, plain_cp;
    logic [10:0] plane;

    function automatic cmd_t utf8_cmd(input logic [20:0] cp);
        cmd_t c;
        c          = '0;
        c.kind     = CMD_UTF8;
        if (cp < 21'h80) begin
            c.nbytes_m1 = 2'd0;
            c.bytes     = {24'd0, 1'b0, cp[6:0]};
        end else if (cp < 21'h800) begin
            c.nbytes_m1 = 2'd1;
            c.bytes     = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
        end else if (cp < 21'h10000) begin
            c.nbytes_m1 = 2'd2;
            c.bytes     = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
        end else begin
            c.nbytes_m1 = 2'd3;
            c.bytes     = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                           5'b11110, cp[20:18]};
        end
        return c;
    endfunction

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign is_low   = (s_tdata[15:10] == 6'b110111);
    assign is_high  = (s_tdata[15:10] == 6'b110110);
    assign plane    = {1'b0, payload_reg} + 11'd64;
    assign pair_cp  = {plane[10:0], s_tdata[9:0]};
    assign plain_cp = {5'd0, s_tdata};

    always_comb begin
        keep_next    = cfg_valid ? cfg_data : keep_reg;
        pending_next = pending_reg;
        payload_next = payload_reg;
        latched_next = latched_reg;
        push         = 1'b0;
        push_cmd     = '0;
        if (accept) begin
            if (latched_reg) begin
                // drop until the end of the string
                if (s_tlast) begin
                    latched_next = 1'b0;
                    pending_next = 1'b0;
                    payload_next = '0;
                end
            end else if (pending_reg) begin
                push         = 1'b1;
                pending_next = 1'b0;
                payload_next = '0;
                if (!is_low) begin
                    push_cmd.kind     = CMD_ERROR;
                    push_cmd.run_last = 1'b1;
                    latched_next      = !s_tlast;
                end else begin
                    push_cmd = utf8_cmd(pair_cp);
                end
            end else if (unit_passes(s_tdata, keep_reg)) begin
                push          = 1'b1;
                push_cmd.kind = CMD_PASS;
                push_cmd.ch   = s_tdata[6:0];
            end else if (is_low || (is_high && s_tlast)) begin
                push              = 1'b1;
                push_cmd.kind     = CMD_ERROR;
                push_cmd.run_last = 1'b1;
                latched_next      = !s_tlast;
            end else if (is_high) begin
                pending_next = 1'b1;
                payload_next = s_tdata[9:0];
            end else begin
                push     = 1'b1;
                push_cmd = utf8_cmd(plain_cp);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_reg    <= 1'b0;
            pending_reg <= 1'b0;
            payload_reg <= '0;
            latched_reg <= 1'b0;
        end else begin
            keep_reg    <= keep_next;
            pending_reg <= pending_next;
            payload_reg <= payload_next;
            latched_reg <= latched_next;
        end
    end

endmodule

// ===== rtl/uri_back.sv =====
// Output side: expands queued jobs into one ASCII character per cycle while m_tready allows.
module uri_back
    import uri_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  cmd_t       head_cmd,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic       m_tuser
);

    digit_t     digit_reg, digit_next;
    logic [1:0] byte_reg, byte_next;
    logic       valid_reg, valid_next;
    logic [6:0] char_reg, char_next;
    logic       last_reg, last_next;
    logic       err_reg, err_next;

    logic       load;
    logic [7:0] cur_byte;
    logic [6:0] gen_char;
    logic       gen_last;
    logic       gen_err;

    assign load     = head_valid && (!valid_reg || m_tready);
    assign cur_byte = head_cmd.bytes[{byte_reg, 3'b000} +: 8];

    always_comb begin
        gen_char = '0;
        gen_last = 1'b1;
        gen_err  = 1'b0;
        case (head_cmd.kind)
            CMD_PASS: begin
                gen_char = head_cmd.ch;
            end
            CMD_ERROR: begin
                gen_err  = 1'b1;
                gen_last = head_cmd.run_last;
            end
            CMD_UTF8: begin
                gen_last = (digit_reg == DIG_LO) && (byte_reg == head_cmd.nbytes_m1);
                case (digit_reg)
                    DIG_PCT: gen_char = CHAR_PCT;
                    DIG_HI:  gen_char = hex_char(cur_byte[7:4]);
                    DIG_LO:  gen_char = hex_char(cur_byte[3:0]);
                    default: gen_char = CHAR_PCT;
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        digit_next = digit_reg;
        byte_next  = byte_reg;
        pop        = 1'b0;
        valid_next = valid_reg && !m_tready;
        char_next  = char_reg;
        last_next  = last_reg;
        err_next   = err_reg;
        if (load) begin
            valid_next = 1'b1;
            char_next  = gen_char;
            last_next  = gen_last;
            err_next   = gen_err;
            if (gen_last) begin
                // job done: release the queue entry
                pop        = 1'b1;
                digit_next = DIG_PCT;
                byte_next  = '0;
            end else begin
                case (digit_reg)
                    DIG_PCT: digit_next = DIG_HI;
                    DIG_HI:  digit_next = DIG_LO;
                    DIG_LO: begin
                        digit_next = DIG_PCT;
                        byte_next  = byte_reg + 1'b1;
                    end
                    default: digit_next = DIG_PCT;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_reg <= DIG_PCT;
            byte_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            digit_reg <= digit_next;
            byte_reg  <= byte_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
        last_reg <= last_next;
        err_reg  <= err_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = err_reg;

endmodule

// ===== rtl/uri_percent_utf8_encoder.sv =====
// Percent-encodes a UTF-16 code unit stream into URI text, one ASCII character
// per output transfer. Unreserved chars (reserved ones too with keep_reserved)
// pass as one character, every other code point becomes 1 to 4 UTF-8 bytes
// written as %XX; a held high surrogate or a dropped unit gives no output. The
// output side emits one character per cycle unless m_tready stalls it; an input
// unit is taken every cycle while the 4-entry job queue between the input
// classifier and the character generator has room, so sustained throughput is
// set by the character count. A malformed surrogate sequence gives one transfer
// with tuser set and the rest of that string is dropped up to its tlast.
// keep_reserved (cfg_data) may only be written while the block is idle.
module uri_percent_utf8_encoder
    import uri_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,    // keep_reserved
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [15:0] code_unit
    input  logic        s_tlast,     // last_unit
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [6:0] out_char, [7] zero
    output logic        m_tlast,     // run_last
    output logic        m_tuser      // error
);

    logic queue_full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    assign cfg_ready = 1'b1;

    uri_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    uri_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    uri_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

// ===== rtl/uri_checker.sv =====
// Port-level checks of the URI percent encoder, bound to the top level.
`include "assert_macros.svh"

module uri_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // an error transfer carries no character and closes its unit
    `ASSERT_IMPL(a_err_shape, m_tvalid && m_tuser, m_tlast && (m_tdata == 8'h00))

    // a percent sign always opens an escape, never ends a unit
    `ASSERT_IMPL(a_pct_not_last, m_tvalid && (m_tdata[6:0] == 7'h25), !m_tlast && !m_tuser)

    // a percent sign is followed by an uppercase hex digit
    `ASSERT_NEXT(a_pct_then_hex, m_tvalid && m_tready && (m_tdata[6:0] == 7'h25), !m_tvalid || ((m_tdata >= 8'h30 && m_tdata <= 8'h39) || (m_tdata >= 8'h41 && m_tdata <= 8'h46)))

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

endmodule

bind uri_percent_utf8_encoder uri_checker u_checker (.*);
